@@ rtl/mcpw_pkg.sv @@
// Package for the multi-channel pulse width capture block.
// Holds field widths, register indexes, reset values and the queued event type.
// No dependencies; every other file imports it.
package mcpw_pkg;

  // number of captured channels
  localparam int CHANNELS  = 8;
  // index bits needed to address one channel
  localparam int IDX_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  // fixed field widths
  localparam int CH_W      = 3;
  localparam int WIDTH_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;
  // channel field widened so that it can be compared with CHANNELS
  localparam int CHX_W     = CH_W + IDX_W + 1;

  localparam logic [WIDTH_W-1:0] MIN_WIDTH_RESET = WIDTH_W'(1000);
  localparam logic [WIDTH_W-1:0] MAX_WIDTH_RESET = WIDTH_W'(2000);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MONITORED = 2'd0,
    REG_MIN_WIDTH = 2'd1,
    REG_MAX_WIDTH = 2'd2
  } cfg_reg_t;

  // classified edge event, as it travels from front to back
  typedef struct packed {
    logic               ch_ok;   // channel exists
    logic [IDX_W-1:0]   idx;     // channel index
    logic               rise;    // pulse start
    logic [WIDTH_W-1:0] stamp;
  } evt_cmd_t;

  // queue status seen by the front
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

@@ rtl/mcpw_event_if.sv @@
// Edge event channel: valid/ready handshake with channel, level and stamp.
// Depends on mcpw_pkg for field widths.
interface mcpw_event_if
  import mcpw_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [CH_W-1:0]    channel;
  logic               level;
  logic [WIDTH_W-1:0] stamp;

  modport source (output valid, channel, level, stamp, input ready);
  modport sink   (input valid, channel, level, stamp, output ready);
endinterface

@@ rtl/mcpw_result_if.sv @@
// Result channel: valid/ready handshake with pulse width and range flag.
// Depends on mcpw_pkg for field widths.
interface mcpw_result_if
  import mcpw_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [WIDTH_W-1:0] pulse_width;
  logic               in_range;

  modport source (output valid, pulse_width, in_range, input ready);
  modport sink   (input valid, pulse_width, in_range, output ready);
endinterface

@@ rtl/mcpw_cfg_if.sv @@
// Configuration write channel: valid/ready handshake with index and data.
// Depends on mcpw_pkg for field widths.
interface mcpw_cfg_if
  import mcpw_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/mcpw_front.sv @@
// Front part: accepts edge events and classifies them for the queue.
// Depends on mcpw_pkg and mcpw_event_if.
module mcpw_front
  import mcpw_pkg::*;
(
  mcpw_event_if.sink evt,
  input  q_status_t  q_stat,
  output logic       push,
  output evt_cmd_t   push_cmd
);

  logic [CHX_W-1:0] ch_ext;

  // take an event whenever the queue has room
  assign evt.ready = !q_stat.full;
  assign push      = evt.valid && !q_stat.full;

  // classify: channel check, index, edge direction
  assign ch_ext         = {{(IDX_W + 1){1'b0}}, evt.channel};
  assign push_cmd.ch_ok = (ch_ext < CHX_W'(CHANNELS));
  assign push_cmd.idx   = ch_ext[IDX_W-1:0];
  assign push_cmd.rise  = evt.level;
  assign push_cmd.stamp = evt.stamp;

endmodule

@@ rtl/mcpw_queue.sv @@
// Two-entry queue of classified events between front and back.
// Depends on mcpw_pkg.
module mcpw_queue
  import mcpw_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  evt_cmd_t  push_cmd,
  input  logic      pop,
  output evt_cmd_t  head,
  output q_status_t stat
);

  evt_cmd_t   slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign head       = slot[rd_ptr];
  assign stat.full  = (count == 2'd2);
  assign stat.empty = (count == 2'd0);

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // store payload
  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= push_cmd;
  end

endmodule

@@ rtl/mcpw_back.sv @@
// Back part: per-channel read-modify-write, range check and result register.
// Also holds the configuration registers. Depends on mcpw_pkg and the interfaces.
module mcpw_back
  import mcpw_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  evt_cmd_t   head,
  input  q_status_t  q_stat,
  output logic       pop,
  mcpw_cfg_if.sink   cfg,
  mcpw_result_if.source res
);

  logic [WIDTH_W-1:0] start_time  [CHANNELS];
  logic [WIDTH_W-1:0] width_store [CHANNELS];
  logic [CH_W-1:0]    monitored_channel;
  logic [WIDTH_W-1:0] min_width;
  logic [WIDTH_W-1:0] max_width;

  logic [CHX_W-1:0]   mon_ext;
  logic               mon_ok;
  logic [IDX_W-1:0]   mon_idx;
  logic [WIDTH_W-1:0] new_width;
  logic               hit;
  logic [WIDTH_W-1:0] width_next;
  logic               in_range_next;

  // drain the queue when the result register is free or being taken
  assign pop = !q_stat.empty && (!res.valid || res.ready);

  assign cfg.ready = 1'b1;

  // new width for the event's channel
  assign new_width = head.rise ? '0 : (head.stamp - start_time[head.idx]);

  // monitored channel, with bypass of this event's update
  assign mon_ext = {{(IDX_W + 1){1'b0}}, monitored_channel};
  assign mon_ok  = (mon_ext < CHX_W'(CHANNELS));
  assign mon_idx = mon_ext[IDX_W-1:0];
  assign hit     = head.ch_ok && (head.idx == mon_idx);

  always_comb begin
    if (!mon_ok)  width_next = '0;
    else if (hit) width_next = new_width;
    else          width_next = width_store[mon_idx];
  end

  assign in_range_next = mon_ok && (width_next >= min_width) && (width_next <= max_width);

  // hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      monitored_channel <= '0;
      min_width         <= MIN_WIDTH_RESET;
      max_width         <= MAX_WIDTH_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_MONITORED: monitored_channel <= cfg.data[CH_W-1:0];
        REG_MIN_WIDTH: min_width         <= cfg.data[WIDTH_W-1:0];
        REG_MAX_WIDTH: max_width         <= cfg.data[WIDTH_W-1:0];
        default:       ;
      endcase
    end
  end

  // update per-channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        start_time[i]  <= '0;
        width_store[i] <= '0;
      end
    end else if (pop && head.ch_ok) begin
      width_store[head.idx] <= new_width;
      if (head.rise) start_time[head.idx] <= head.stamp;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (pop) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (pop) begin
      res.pulse_width <= width_next;
      res.in_range    <= in_range_next;
    end
  end

endmodule

@@ rtl/multi_channel_pulse_width_capture.sv @@
// Channel  Dir  Handshake    Payload
// evt      in   valid/ready  channel[2:0], level, stamp[15:0]
// cfg      in   valid/ready  index[1:0], data[15:0]
// res      out  valid/ready  pulse_width[15:0], in_range
//
// One edge event is accepted per cycle while the queue has room; every event gives one result.
// An accepted event is written to the queue; the back then pops it, updates channel
// state and loads the result register when free. The back's update sets the rate.
// Synchronous reset clears channel state, queue and result valid.
// A stalled result stops the back; the two-entry queue then fills and drops evt.ready.
// Top level: wires front, queue and back. Depends on mcpw_pkg, the interfaces
// and the mcpw_front, mcpw_queue, mcpw_back modules.
module multi_channel_pulse_width_capture
  import mcpw_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  mcpw_event_if.sink    evt,
  mcpw_cfg_if.sink      cfg,
  mcpw_result_if.source res
);

  q_status_t q_stat;
  logic      push;
  evt_cmd_t  push_cmd;
  logic      pop;
  evt_cmd_t  head;

  mcpw_front u_front (
    .evt      (evt),
    .q_stat   (q_stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  mcpw_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  mcpw_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .cfg    (cfg),
    .res    (res)
  );

endmodule

@@ rtl/mcpw_checker.sv @@
// Port-level checker for the pulse width capture block, with its bind.
// Depends on mcpw_pkg and the top level's port names.
module mcpw_checker
  import mcpw_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               evt_valid,
  input logic               evt_ready,
  input logic               res_valid,
  input logic               res_ready,
  input logic [WIDTH_W-1:0] res_pulse_width,
  input logic               res_in_range
);

  logic [2:0] pending;
  logic       evt_take;
  logic       res_take;

  assign evt_take = evt_valid && evt_ready;
  assign res_take = res_valid && res_ready;

  // count transactions in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      case ({evt_take, res_take})
        2'b10:   pending <= pending + 3'd1;
        2'b01:   pending <= pending - 3'd1;
        default: pending <= pending;
      endcase
    end
  end

  // after reset: empty pipeline, input open
  a_reset_state: assert property (@(posedge clk) rst |=> (evt_ready && !res_valid))
    else $error("block not idle after reset");

  // no result without an accepted event, never more than queue plus output
  a_pending: assert property (@(posedge clk) disable iff (rst)
    (!res_valid || (pending != 3'd0)) && (pending <= 3'd3))
    else $error("result count does not match accepted events");

  // a stalled result stays valid
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> res_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> ($stable(res_pulse_width) && $stable(res_in_range)))
    else $error("result payload changed while stalled");

endmodule

bind multi_channel_pulse_width_capture mcpw_checker u_mcpw_checker (
  .clk             (clk),
  .rst             (rst),
  .evt_valid       (evt.valid),
  .evt_ready       (evt.ready),
  .res_valid       (res.valid),
  .res_ready       (res.ready),
  .res_pulse_width (res.pulse_width),
  .res_in_range    (res.in_range)
);
